// ===== rtl/core/fpvm_pkg.sv =====
`timescale 1ns / 1ps

package fpvm_pkg;

	localparam int VOLT_W      = 16;
	localparam int REG_W       = 15;
	localparam int COUNT_W     = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int FULL_SCALE  = 10000;
	localparam int SINE_POINTS = 64;
	// 2 * sqrt(3)/2 * 2^16 scaled down by 4
	localparam int SQRT3_Q     = 28378;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd2;

	typedef struct packed {
		logic signed [VOLT_W-1:0] quad_voltage;
		logic signed [VOLT_W-1:0] direct_voltage;
		logic [VOLT_W-1:0]        elec_angle;
	} req_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] compare_a;
		logic [COUNT_W-1:0] compare_b;
		logic [COUNT_W-1:0] compare_c;
	} req_out_t;

	// base point and slope of one interpolation segment
	typedef struct packed {
		logic signed [16:0] t1;
		logic signed [16:0] dt;
	} interp_t;

	function automatic logic signed [16:0] sine_entry(input logic [6:0] idx);
		logic [15:0] v;
		case (idx)
			7'd0: v = 16'd0;      7'd1: v = 16'd804;    7'd2: v = 16'd1608;
			7'd3: v = 16'd2411;   7'd4: v = 16'd3212;   7'd5: v = 16'd4011;
			7'd6: v = 16'd4808;   7'd7: v = 16'd5602;   7'd8: v = 16'd6393;
			7'd9: v = 16'd7180;   7'd10: v = 16'd7962;  7'd11: v = 16'd8740;
			7'd12: v = 16'd9512;  7'd13: v = 16'd10279; 7'd14: v = 16'd11039;
			7'd15: v = 16'd11793; 7'd16: v = 16'd12540; 7'd17: v = 16'd13279;
			7'd18: v = 16'd14010; 7'd19: v = 16'd14733; 7'd20: v = 16'd15447;
			7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17531;
			7'd24: v = 16'd18205; 7'd25: v = 16'd18868; 7'd26: v = 16'd19520;
			7'd27: v = 16'd20160; 7'd28: v = 16'd20788; 7'd29: v = 16'd21403;
			7'd30: v = 16'd22006; 7'd31: v = 16'd22595; 7'd32: v = 16'd23170;
			7'd33: v = 16'd23732; 7'd34: v = 16'd24279; 7'd35: v = 16'd24812;
			7'd36: v = 16'd25330; 7'd37: v = 16'd25833; 7'd38: v = 16'd26320;
			7'd39: v = 16'd26791; 7'd40: v = 16'd27246; 7'd41: v = 16'd27684;
			7'd42: v = 16'd28106; 7'd43: v = 16'd28511; 7'd44: v = 16'd28899;
			7'd45: v = 16'd29269; 7'd46: v = 16'd29622; 7'd47: v = 16'd29957;
			7'd48: v = 16'd30274; 7'd49: v = 16'd30572; 7'd50: v = 16'd30853;
			7'd51: v = 16'd31114; 7'd52: v = 16'd31357; 7'd53: v = 16'd31581;
			7'd54: v = 16'd31786; 7'd55: v = 16'd31972; 7'd56: v = 16'd32138;
			7'd57: v = 16'd32286; 7'd58: v = 16'd32413; 7'd59: v = 16'd32522;
			7'd60: v = 16'd32610; 7'd61: v = 16'd32679; 7'd62: v = 16'd32729;
			7'd63: v = 16'd32758;
			default: v = 16'd32768;
		endcase
		return $signed({1'b0, v});
	endfunction

	// quadrant fold: odd quadrants run the table backward, upper half negates
	function automatic interp_t sine_segment(input logic [15:0] ang);
		logic [6:0] k;
		logic [6:0] i1;
		logic [6:0] i2;
		logic signed [16:0] a;
		logic signed [16:0] b;
		interp_t r;
		k  = {1'b0, ang[13:8]};
		i1 = ang[14] ? 7'd64 - k : k;
		i2 = ang[14] ? 7'd63 - k : k + 7'd1;
		a  = sine_entry(i1);
		b  = sine_entry(i2);
		if (ang[15]) begin
			a = -a;
			b = -b;
		end
		r.t1 = a;
		r.dt = b - a;
		return r;
	endfunction

endpackage

// ===== rtl/core/foc_phase_voltage_modulator.sv =====
`timescale 1ns / 1ps

// Sinusoidal PWM modulator: inverse Park + inverse Clarke, then offset and duty.
// Input channel (in_valid / in_stall / in_req): Uq, Ud (signed Q8.8) and the
//   electrical angle (65536 = one turn). Taken at an edge with in_valid high
//   and in_stall low.
// Output channel (out_valid / out_stall / out_req): three compare counts in
//   0..10000, one request per input request, in order.
// Config port: cfg_we writes cfg_data to register cfg_idx (0 limit, 1 supply,
//   2 centered mode); other indexes are ignored. Write only while idle.
// Throughput: one request per cycle while out_stall is low. The depth is set by the
//   14-bit restoring divider (one quotient bit per stage) that divides by the supply
//   voltage.
// Reset clears all valid bits and loads limit 3072, supply 3072, centered 1.
// When the receiver stalls, the output holds and the pipeline keeps filling
//   its empty stages; in_stall rises only once every stage is occupied.
module foc_phase_voltage_modulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  fpvm_pkg::req_in_t                 in_req,
	output logic                              out_valid,
	input  logic                              out_stall,
	output fpvm_pkg::req_out_t                out_req,
	input  logic                              cfg_we,
	input  logic [fpvm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fpvm_pkg::REG_W-1:0]        cfg_data
);

	localparam int NST = 27;
	localparam int DIV = fpvm_pkg::COUNT_W;
	localparam int PW  = 56;   // phase voltage word, 2^-30 Q8.8 LSB units
	localparam int UW  = 45;   // clamped phase, 0..limit<<30
	localparam int NW  = 29;   // dividend after dropping 30 low bits

	// configuration
	logic [fpvm_pkg::REG_W-1:0] limit_q;
	logic [fpvm_pkg::REG_W-1:0] supply_q;
	logic                       center_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= 15'd3072;
			supply_q <= 15'd3072;
			center_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fpvm_pkg::REG_LIMIT:  limit_q  <= cfg_data;
				fpvm_pkg::REG_SUPPLY: supply_q <= cfg_data;
				fpvm_pkg::REG_CENTER: center_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage valid / ready chain; bubbles collapse under stall
	logic [NST:1]   vld;
	logic [NST+1:1] rdy;

	always_comb begin
		rdy[NST+1] = !out_stall;
		for (int k = NST; k >= 1; k--) rdy[k] = !vld[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= in_valid;
			for (int k = 2; k <= NST; k++) if (rdy[k]) vld[k] <= vld[k-1];
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld[NST];

	// s1: table lookup for sine and cosine segments
	fpvm_pkg::interp_t   seg_sin, seg_cos;
	fpvm_pkg::interp_t   sin_seg_s1, cos_seg_s1;
	logic [7:0]          frac_s1;
	logic signed [15:0]  uq_s1, ud_s1;

	assign seg_sin = fpvm_pkg::sine_segment(in_req.elec_angle);
	assign seg_cos = fpvm_pkg::sine_segment(in_req.elec_angle + 16'd16384);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			sin_seg_s1 <= seg_sin;
			cos_seg_s1 <= seg_cos;
			frac_s1    <= in_req.elec_angle[7:0];
			uq_s1      <= in_req.quad_voltage;
			ud_s1      <= in_req.direct_voltage;
		end
	end

	// s2: linear interpolation, floor of slope * frac / 256
	logic signed [25:0] sin_step, cos_step;
	logic signed [16:0] sin_s2, cos_s2;
	logic signed [15:0] uq_s2, ud_s2;

	assign sin_step = sin_seg_s1.dt * $signed({1'b0, frac_s1});
	assign cos_step = cos_seg_s1.dt * $signed({1'b0, frac_s1});

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			sin_s2 <= sin_seg_s1.t1 + 17'(sin_step >>> 8);
			cos_s2 <= cos_seg_s1.t1 + 17'(cos_step >>> 8);
			uq_s2  <= uq_s1;
			ud_s2  <= ud_s1;
		end
	end

	// s3: inverse Park products
	logic signed [32:0] cd_s3, sq_s3, sd_s3, cq_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			cd_s3 <= cos_s2 * ud_s2;
			sq_s3 <= sin_s2 * uq_s2;
			sd_s3 <= sin_s2 * ud_s2;
			cq_s3 <= cos_s2 * uq_s2;
		end
	end

	// s4: alpha / beta
	logic signed [33:0] alpha_s4, beta_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			alpha_s4 <= 34'(cd_s3) - 34'(sq_s3);
			beta_s4  <= 34'(sd_s3) + 34'(cq_s3);
		end
	end

	// s5: beta * sqrt(3) term
	logic signed [51:0] bk_s5;
	logic signed [33:0] alpha_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			bk_s5    <= beta_s4 * $signed(18'(fpvm_pkg::SQRT3_Q));
			alpha_s5 <= alpha_s4;
		end
	end

	// s6: inverse Clarke, doubled phases scaled by 1/4 (all even)
	logic signed [PW-1:0] ph_s6 [3];
	logic signed [PW-1:0] ah;

	assign ah = PW'(alpha_s5) <<< 14;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			ph_s6[0] <= PW'(alpha_s5) <<< 15;
			ph_s6[1] <= -ah + PW'(bk_s5);
			ph_s6[2] <= -ah - PW'(bk_s5);
		end
	end

	// s7: min / max
	logic signed [PW-1:0] ph_s7 [3];
	logic signed [PW-1:0] lo_s7, hi_s7;
	logic signed [PW-1:0] lo_n, hi_n;

	always_comb begin
		lo_n = (ph_s6[0] < ph_s6[1]) ? ph_s6[0] : ph_s6[1];
		if (ph_s6[2] < lo_n) lo_n = ph_s6[2];
		hi_n = (ph_s6[0] > ph_s6[1]) ? ph_s6[0] : ph_s6[1];
		if (ph_s6[2] > hi_n) hi_n = ph_s6[2];
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			ph_s7 <= ph_s6;
			lo_s7 <= lo_n;
			hi_s7 <= hi_n;
		end
	end

	// s8: common-mode offset
	logic signed [PW-1:0] ph_s8 [3];
	logic signed [PW-1:0] off_s8;
	logic signed [PW-1:0] mid_ref;

	assign mid_ref = PW'($signed({1'b0, limit_q})) <<< 29;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			ph_s8  <= ph_s7;
			off_s8 <= center_q ? mid_ref - ((hi_s7 + lo_s7) >>> 1) : -lo_s7;
		end
	end

	// s9: apply offset
	logic signed [PW-1:0] vs_s9 [3];

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			for (int p = 0; p < 3; p++) vs_s9[p] <= ph_s8[p] + off_s8;
		end
	end

	// s10: clamp to 0..limit; a zero limit clamps every phase to zero
	logic [UW-1:0] top_v;
	logic [UW-1:0] vu_s10 [3];
	logic [2:0]    nz_s10;

	assign top_v = {limit_q, 30'd0};

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			for (int p = 0; p < 3; p++) begin
				if (vs_s9[p] < 0) vu_s10[p] <= '0;
				else if (vs_s9[p] > $signed({{(PW-UW){1'b0}}, top_v})) vu_s10[p] <= top_v;
				else vu_s10[p] <= vs_s9[p][UW-1:0];
				nz_s10[p] <= (vs_s9[p] > 0) && (limit_q != '0);
			end
		end
	end

	// s11: scale by full count, drop the 2^30 of the divisor
	logic [UW+13:0] prod [3];
	logic [NW-1:0]  n_s11 [3];
	logic [2:0]     nz_s11;

	always_comb begin
		for (int p = 0; p < 3; p++)
			prod[p] = (UW+14)'(vu_s10[p]) * (UW+14)'(fpvm_pkg::FULL_SCALE);
	end

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			for (int p = 0; p < 3; p++) n_s11[p] <= prod[p][UW+13:30];
			nz_s11 <= nz_s10;
		end
	end

	// s12: quotient overflow check (also covers zero supply)
	logic [NW-1:0]       rem_s [0:DIV][3];
	logic [DIV-1:0]      quo_s [0:DIV][3];
	logic [2:0]          ovf_s [0:DIV];
	logic [2:0]          nz_s  [0:DIV];
	logic [NW-1:0]       sup_top;

	assign sup_top = {supply_q, 14'd0};

	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			for (int p = 0; p < 3; p++) begin
				rem_s[0][p]  <= n_s11[p];
				quo_s[0][p]  <= '0;
				ovf_s[0][p]  <= n_s11[p] >= sup_top;
			end
			nz_s[0] <= nz_s11;
		end
	end

	// s13..s26: restoring divide, one quotient bit per stage
	for (genvar k = 0; k < DIV; k++) begin : g_div
		logic [NW-1:0] dsh;
		assign dsh = NW'(supply_q) << (DIV - 1 - k);

		always_ff @(posedge clk) begin
			if (rdy[13+k]) begin
				for (int p = 0; p < 3; p++) begin
					if (rem_s[k][p] >= dsh) begin
						rem_s[k+1][p] <= rem_s[k][p] - dsh;
						quo_s[k+1][p] <= quo_s[k][p] | (DIV'(1) << (DIV - 1 - k));
					end else begin
						rem_s[k+1][p] <= rem_s[k][p];
						quo_s[k+1][p] <= quo_s[k][p];
					end
				end
				ovf_s[k+1] <= ovf_s[k];
				nz_s[k+1]  <= nz_s[k];
			end
		end
	end

	// s27: saturate and drive the output register
	localparam logic [DIV-1:0] FS = DIV'(fpvm_pkg::FULL_SCALE);
	logic [DIV-1:0] cnt [3];

	always_comb begin
		for (int p = 0; p < 3; p++) begin
			if (!nz_s[DIV][p]) cnt[p] = '0;
			else if (ovf_s[DIV][p] || quo_s[DIV][p] > FS) cnt[p] = FS;
			else cnt[p] = quo_s[DIV][p];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST]) begin
			out_req.compare_a <= cnt[0];
			out_req.compare_b <= cnt[1];
			out_req.compare_c <= cnt[2];
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_req.compare_a <= FS && out_req.compare_b <= FS
			&& out_req.compare_c <= FS))
		else $error("compare count above full scale");

	a_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[11] && !nz_s11[0]) |-> (n_s11[0] == '0))
		else $error("zero phase with nonzero dividend");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

// ===== test/tb_foc_phase_voltage_modulator.sv =====
`timescale 1ns / 1ps

module tb_foc_phase_voltage_modulator;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	fpvm_pkg::req_in_t in_req = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fpvm_pkg::req_out_t out_req;
	logic cfg_we = 1'b0;
	logic [fpvm_pkg::CFG_IDX_W-1:0] cfg_idx = fpvm_pkg::REG_LIMIT;
	logic [fpvm_pkg::REG_W-1:0] cfg_data = '0;

	foc_phase_voltage_modulator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_req(out_req),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor's copy of the register file
	int unsigned volt_limit = 3072;
	int unsigned bus_supply = 3072;
	bit center_on = 1'b1;

	fpvm_pkg::req_in_t pending_reqs[$];
	fpvm_pkg::req_out_t expected_counts[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int checked = 0;
	int cfg_writes = 0;

	localparam longint SQRT3_2X = 113512; // 2 * 56756
	// index past the last register
	localparam logic [fpvm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	function automatic longint quarter_lookup(input int idx);
		if (idx < 0) idx = 0;
		if (idx > 64) idx = 64;
		return longint'(fpvm_pkg::sine_entry(7'(idx)));
	endfunction

	// Q1.15 sine with quadrant folding and 8-bit interpolation, floor rounding
	function automatic longint sine_of_angle(input logic [15:0] ang);
		int i;
		int frac;
		longint t1;
		longint t2;
		longint d;
		i = int'(ang[15:8]);
		frac = int'(ang[7:0]);
		if (i < 64) begin
			t1 = quarter_lookup(i); t2 = quarter_lookup(i + 1);
		end else if (i < 128) begin
			t1 = quarter_lookup(128 - i); t2 = quarter_lookup(127 - i);
		end else if (i < 192) begin
			t1 = -quarter_lookup(i - 128); t2 = -quarter_lookup(i - 127);
		end else begin
			t1 = -quarter_lookup(256 - i); t2 = -quarter_lookup(255 - i);
		end
		d = (t2 - t1) * frac;
		if (d >= 0) d = d / 256;
		else d = -((-d + 255) / 256);
		return t1 + d;
	endfunction

	// doubled phase voltage (2^-31 LSB units) to a saturated compare count
	function automatic logic [fpvm_pkg::COUNT_W-1:0] duty_count(input longint v2);
		longint top;
		longint q;
		top = longint'(volt_limit) <<< 32;
		if (v2 < 0) v2 = 0;
		if (v2 > top) v2 = top;
		if (v2 == 0) return '0;
		if (bus_supply == 0) return fpvm_pkg::COUNT_W'(fpvm_pkg::FULL_SCALE);
		q = (v2 * fpvm_pkg::FULL_SCALE) / (longint'(bus_supply) <<< 32);
		if (q > fpvm_pkg::FULL_SCALE) q = fpvm_pkg::FULL_SCALE;
		return fpvm_pkg::COUNT_W'(q);
	endfunction

	function automatic fpvm_pkg::req_out_t compute_compares(input fpvm_pkg::req_in_t r);
		longint uq, ud, s, c, alpha, beta, a2, b2, c2, lo, hi, off;
		fpvm_pkg::req_out_t o;
		uq = longint'($signed(r.quad_voltage));
		ud = longint'($signed(r.direct_voltage));
		s = sine_of_angle(r.elec_angle);
		c = sine_of_angle(r.elec_angle + 16'd16384);
		alpha = c * ud - s * uq;
		beta = s * ud + c * uq;
		a2 = alpha * 131072;
		b2 = -alpha * 65536 + beta * SQRT3_2X;
		c2 = -alpha * 65536 - beta * SQRT3_2X;
		lo = a2 < b2 ? a2 : b2;
		lo = lo < c2 ? lo : c2;
		hi = a2 > b2 ? a2 : b2;
		hi = hi > c2 ? hi : c2;
		// midpoint clamp centers the phases on half the limit
		if (center_on) off = (longint'(volt_limit) <<< 31) - (hi + lo) / 2;
		else off = -lo;
		o.compare_a = duty_count(a2 + off);
		o.compare_b = duty_count(b2 + off);
		o.compare_c = duty_count(c2 + off);
		return o;
	endfunction

	// driver: a request leaves when accepted; next one goes out unless idling
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_counts.push_back(compute_compares(in_req));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_req <= pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_req);
					errors++;
				end else begin
					fpvm_pkg::req_out_t e;
					e = expected_counts.pop_front();
					checked++;
					if (e.compare_a !== out_req.compare_a) begin
						$display("%0t: compare_a exp %0d got %0d", $time, e.compare_a,
							out_req.compare_a);
						errors++;
					end
					if (e.compare_b !== out_req.compare_b) begin
						$display("%0t: compare_b exp %0d got %0d", $time, e.compare_b,
							out_req.compare_b);
						errors++;
					end
					if (e.compare_c !== out_req.compare_c) begin
						$display("%0t: compare_c exp %0d got %0d", $time, e.compare_c,
							out_req.compare_c);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [fpvm_pkg::CFG_IDX_W-1:0] idx,
		input logic [fpvm_pkg::REG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// mirror: out-of-range index is ignored by the block
		case (idx)
			fpvm_pkg::REG_LIMIT: volt_limit = 32'(val);
			fpvm_pkg::REG_SUPPLY: bus_supply = 32'(val);
			fpvm_pkg::REG_CENTER: center_on = val[0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic queue_req(input logic [15:0] q, input logic [15:0] d,
		input logic [15:0] a);
		fpvm_pkg::req_in_t r;
		r.quad_voltage = q;
		r.direct_voltage = d;
		r.elec_angle = a;
		pending_reqs.push_back(r);
	endtask

	// random requests: mostly moderate amplitudes so counts land mid-range
	task automatic queue_random(input int n);
		logic [15:0] q, d;
		repeat (n) begin
			case ($urandom_range(3))
				0: begin q = 16'($urandom); d = 16'($urandom); end
				1: begin
					q = 16'($signed(12'($urandom)));
					d = 16'($signed(12'($urandom)));
				end
				default: begin
					q = 16'($signed(10'($urandom)));
					d = 16'($signed(8'($urandom)));
				end
			endcase
			queue_req(q, d, 16'($urandom));
		end
	endtask

	task automatic drain;
		while (pending_reqs.size() > 0 || expected_counts.size() > 0 || in_valid)
			@(posedge clk);
		// covers the pipeline depth before touching registers
		repeat (40) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 34;
		recv_stall_pct = 53;

		// directed: field extremes, quadrant edges, reset register values
		queue_req(16'h7FFF, 16'h0000, 16'd0);
		queue_req(16'h8000, 16'h0000, 16'd16384);
		queue_req(16'h0000, 16'h7FFF, 16'd32768);
		queue_req(16'h0000, 16'h8000, 16'd49152);
		queue_req(16'h7FFF, 16'h7FFF, 16'hFFFF);
		queue_req(16'h8000, 16'h8000, 16'h00FF);
		queue_req(16'h0000, 16'h0000, 16'h5555);
		queue_req(16'hFFFF, 16'h0001, 16'hAAAA);
		queue_req(16'h0100, 16'h0000, 16'd16383);
		queue_req(16'h0100, 16'h0000, 16'd32767);
		queue_req(16'h0100, 16'h0000, 16'd49151);
		queue_req(16'h0100, 16'hFF00, 16'd65280);
		queue_req(16'h0A00, 16'h0000, 16'd8192);
		queue_req(16'h0600, 16'h0300, 16'd40000);
		queue_random(280);
		drain();

		// shift-to-minimum, widest limit, smallest supply
		write_reg(fpvm_pkg::REG_LIMIT, 15'h7FFF);
		write_reg(fpvm_pkg::REG_SUPPLY, 15'd1);
		write_reg(fpvm_pkg::REG_CENTER, 15'h7FFE); // only bit 0 counts
		queue_req(16'h7FFF, 16'h8000, 16'h1234);
		queue_req(16'h0001, 16'h0000, 16'h0000);
		queue_random(280);
		drain();

		send_idle_pct = 53;
		recv_stall_pct = 34;
		// zero limit, widest supply, centered
		write_reg(fpvm_pkg::REG_LIMIT, 15'd0);
		write_reg(fpvm_pkg::REG_SUPPLY, 15'h7FFF);
		write_reg(fpvm_pkg::REG_CENTER, 15'd1);
		queue_random(280);
		drain();

		// zero supply saturates any nonzero phase; bad index must be ignored
		write_reg(fpvm_pkg::REG_LIMIT, 15'd4096);
		write_reg(fpvm_pkg::REG_SUPPLY, 15'd0);
		write_reg(REG_UNUSED, 15'h1234);
		queue_random(280);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(fpvm_pkg::REG_LIMIT, 15'd6000);
		write_reg(fpvm_pkg::REG_SUPPLY, 15'd6144);
		write_reg(fpvm_pkg::REG_CENTER, 15'd0);
		queue_random(300);
		drain();

		write_reg(fpvm_pkg::REG_LIMIT, 15'($urandom_range(32767)));
		write_reg(fpvm_pkg::REG_SUPPLY, 15'($urandom_range(32767, 1)));
		write_reg(fpvm_pkg::REG_CENTER, 15'd1);
		queue_random(300);
		drain();

		$display("Checked %0d compare triples over %0d register writes,", checked, cfg_writes);
		$display("both offset modes, limit/supply extremes and mixed backpressure.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding", expected_counts.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
